// ===== rtl/rcbp_pkg.sv =====
// ============================================================================
// rcbp_pkg
// Shared types and constants for the reference-counted buffer pool.
// ============================================================================
`default_nettype none

package rcbp_pkg;

    // Fixed field widths of the stream payloads
    localparam int OP_W       = 2;
    localparam int ID_W       = 10;
    localparam int CNT_IN_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = 11;
    localparam int POOL_W     = 11;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;

    // Buffer index space and reset values
    localparam int          ID_SPACE       = 1024;
    localparam logic [10:0] POOL_SIZE_RST  = 11'd1024;

    // Defaults for the top-level parameters
    localparam int MAX_BUFFERS_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 8;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_en;
        logic take;
        logic exec;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/rcbp_ctrl.sv =====
// ============================================================================
// rcbp_ctrl
// Controller: count-table clearing pass, item accept and execute sequencing.
// ============================================================================
`default_nettype none

module rcbp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire rcbp_pkg::t_dp_stat i_stat,
    output rcbp_pkg::t_dp_cmd       o_cmd
);

    rcbp_pkg::t_state r_state;
    rcbp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcbp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcbp_pkg::S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = rcbp_pkg::S_IDLE;
                end
            end
            rcbp_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = rcbp_pkg::S_EXEC;
                end
            end
            rcbp_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = rcbp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcbp_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            rcbp_pkg::S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            rcbp_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
            end
            rcbp_pkg::S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rcbp_dpath.sv =====
// ============================================================================
// rcbp_dpath
// Datapath: free stack and count table memories, stack top, pool size
// register, item execution and the result register.
// ============================================================================
`default_nettype none

module rcbp_dpath #(
    parameter int MAX_BUFFERS = rcbp_pkg::MAX_BUFFERS_DEF,
    parameter int COUNT_BITS  = rcbp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rcbp_pkg::t_dp_cmd             i_cmd,
    output rcbp_pkg::t_dp_stat                 o_stat,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rcbp_pkg::POOL_W-1:0]   i_cfg_wr_data,
    input  wire logic [rcbp_pkg::OP_W-1:0]     i_op,
    input  wire logic [rcbp_pkg::ID_W-1:0]     i_buf_id,
    input  wire logic [rcbp_pkg::CNT_IN_W-1:0] i_ref_count,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [rcbp_pkg::STATUS_W-1:0]      o_status,
    output logic [rcbp_pkg::ID_W-1:0]          o_buf_out,
    output logic                               o_released,
    output logic [rcbp_pkg::LEVEL_W-1:0]       o_free_level
);

    localparam int TOP_W  = $clog2(MAX_BUFFERS + 1);
    localparam int ADDR_W = $clog2(MAX_BUFFERS);
    localparam int CMP_W  = (TOP_W > rcbp_pkg::POOL_W) ? TOP_W : rcbp_pkg::POOL_W;

    // Memories
    logic [rcbp_pkg::ID_W-1:0] r_stack [MAX_BUFFERS];
    logic [COUNT_BITS-1:0]     r_refs  [rcbp_pkg::ID_SPACE];

    // Control and item registers
    logic [TOP_W-1:0]            r_top;
    logic [TOP_W-1:0]            n_top;
    logic [rcbp_pkg::POOL_W-1:0] r_pool_size;
    logic [rcbp_pkg::ID_W-1:0]   r_clr_idx;
    rcbp_pkg::t_op               r_op;
    logic [rcbp_pkg::ID_W-1:0]   r_id;
    logic [COUNT_BITS-1:0]       r_cnt;
    logic [rcbp_pkg::ID_W-1:0]   r_stk_rd;
    logic [COUNT_BITS-1:0]       r_ref_rd;

    // Result register
    logic                          r_m_valid;
    rcbp_pkg::t_status             r_status;
    logic [rcbp_pkg::ID_W-1:0]     r_buf_out;
    logic                          r_released;
    logic [rcbp_pkg::LEVEL_W-1:0]  r_level;

    // Execution results
    rcbp_pkg::t_status         status;
    logic [rcbp_pkg::ID_W-1:0] bout;
    logic                      rel;
    logic                      full;
    logic [COUNT_BITS-1:0]     dec_cnt;
    logic                      stk_we;
    logic                      ref_we;
    logic [rcbp_pkg::ID_W-1:0] ref_wa;
    logic [COUNT_BITS-1:0]     ref_wd;
    logic [ADDR_W-1:0]         stk_ra;

    assign stk_ra  = ADDR_W'(r_top - TOP_W'(1));
    assign full    = (r_top == TOP_W'(MAX_BUFFERS)) ||
                     (CMP_W'(r_top) >= CMP_W'(r_pool_size));
    assign dec_cnt = r_ref_rd - COUNT_BITS'(1);

    // Status to the controller
    assign o_stat.clear_last = (r_clr_idx == rcbp_pkg::ID_W'(rcbp_pkg::ID_SPACE - 1));
    assign o_stat.out_free   = !r_m_valid || i_m_tready;

    // Pool size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= rcbp_pkg::POOL_SIZE_RST;
        end else if (i_cfg_wr_en) begin
            r_pool_size <= i_cfg_wr_data;
        end
    end

    // Advance the clearing pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_idx <= r_clr_idx + rcbp_pkg::ID_W'(1);
        end
    end

    // Capture the item and issue both memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= rcbp_pkg::t_op'(i_op);
            r_id     <= i_buf_id;
            r_cnt    <= COUNT_BITS'(i_ref_count);
            r_stk_rd <= r_stack[stk_ra];
            r_ref_rd <= r_refs[i_buf_id];
        end
    end

    // Execute the item on the registered read data
    always_comb begin
        status  = rcbp_pkg::ST_OK;
        bout    = '0;
        rel     = 1'b0;
        n_top   = r_top;
        stk_we  = 1'b0;
        ref_we  = 1'b0;
        ref_wa  = r_id;
        ref_wd  = r_cnt;
        case (r_op)
            rcbp_pkg::OP_ADD: begin
                if (full) begin
                    status = rcbp_pkg::ST_FULL;
                end else begin
                    stk_we = 1'b1;
                    n_top  = r_top + TOP_W'(1);
                end
            end
            rcbp_pkg::OP_ALLOC: begin
                if (r_top == '0) begin
                    status = rcbp_pkg::ST_EMPTY;
                end else begin
                    n_top  = r_top - TOP_W'(1);
                    bout   = r_stk_rd;
                    ref_we = 1'b1;
                    ref_wa = r_stk_rd;
                    ref_wd = r_cnt;
                end
            end
            rcbp_pkg::OP_FREE: begin
                if (r_ref_rd == '0) begin
                    status = rcbp_pkg::ST_ZERO;
                end else begin
                    ref_we = 1'b1;
                    ref_wd = dec_cnt;
                    if (dec_cnt == '0) begin
                        if (full) begin
                            status = rcbp_pkg::ST_FULL;
                        end else begin
                            stk_we = 1'b1;
                            rel    = 1'b1;
                            n_top  = r_top + TOP_W'(1);
                        end
                    end
                end
            end
            default: begin
                status = rcbp_pkg::ST_OK;
            end
        endcase
    end

    // Free stack write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && stk_we) begin
            r_stack[ADDR_W'(r_top)] <= r_id;
        end
    end

    // Count table write port, shared with the clearing pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_refs[r_clr_idx] <= '0;
        end else if (i_cmd.exec && ref_we) begin
            r_refs[ref_wa] <= ref_wd;
        end
    end

    // Stack top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_cmd.exec) begin
            r_top <= n_top;
        end
    end

    // Load the result register, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= status;
            r_buf_out  <= bout;
            r_released <= rel;
            r_level    <= rcbp_pkg::LEVEL_W'(n_top);
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_status     = r_status;
    assign o_buf_out    = r_buf_out;
    assign o_released   = r_released;
    assign o_free_level = r_level;

`ifndef SYNTH
    // The stack never holds more than its depth
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(MAX_BUFFERS))
        else $error("stack top beyond depth");

    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_m_valid || i_m_tready))
        else $error("result register overwritten");

    // A successful allocate pops exactly one entry
    a_alloc_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == rcbp_pkg::OP_ALLOC && r_top != '0)
        |=> (r_top == $past(r_top) - TOP_W'(1)))
        else $error("allocate did not pop");

    // Capture and execution never coincide, nor with the clearing pass
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear_en, i_cmd.take, i_cmd.exec}))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== rtl/refcounted_buffer_pool.sv =====
// ============================================================================
// refcounted_buffer_pool
// Buffer manager with a LIFO free stack of buffer indices and a reference
// count per buffer.
// ============================================================================
// Usage:
//   s_*: one command per transfer; s_tuser is the op (add, allocate, free),
//   s_tdata the buffer index and the initial count.
//   m_*: one result per command; m_tuser is the status, m_tdata the
//   allocated index, the released flag and the free-stack level.
//   i_cfg_wr_en / i_cfg_wr_data write the pool size; write only while idle.
// Timing:
//   After reset the count table is cleared with s_tready low. A command
//   reads the stack and count table at its accept edge and executes once
//   the result register is free, after which m_tvalid rises; s_tready is
//   low until then, so a new command is taken only after the last executes.
// Back-pressure:
//   While a result waits on m_tready low, the next command is still accepted
//   and then held before execution until the result register is free.
// ============================================================================
`default_nettype none

module refcounted_buffer_pool #(
    parameter int MAX_BUFFERS = rcbp_pkg::MAX_BUFFERS_DEF,
    parameter int COUNT_BITS  = rcbp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration: pool size
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rcbp_pkg::POOL_W-1:0]   i_cfg_wr_data,
    // Command stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rcbp_pkg::S_DATA_W-1:0] s_tdata,  // buf_id[9:0], ref_count[17:10]
    input  wire logic [rcbp_pkg::OP_W-1:0]     s_tuser,  // op[1:0]
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rcbp_pkg::M_DATA_W-1:0]      m_tdata,  // buf_out[9:0], released[10],
                                                          // free_level[21:11]
    output logic [rcbp_pkg::STATUS_W-1:0]      m_tuser   // status[1:0]
);

    rcbp_pkg::t_dp_cmd  cmd;
    rcbp_pkg::t_dp_stat stat;

    logic [rcbp_pkg::ID_W-1:0]    buf_out;
    logic                         released;
    logic [rcbp_pkg::LEVEL_W-1:0] free_level;

    rcbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rcbp_dpath #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (s_tuser),
        .i_buf_id      (s_tdata[9:0]),
        .i_ref_count   (s_tdata[17:10]),
        .i_m_tready    (m_tready),
        .o_m_tvalid    (m_tvalid),
        .o_status      (m_tuser),
        .o_buf_out     (buf_out),
        .o_released    (released),
        .o_free_level  (free_level)
    );

    // Pack the result payload
    assign m_tdata = {2'b00, free_level, released, buf_out};

endmodule

`default_nettype wire

// ===== test/refcounted_buffer_pool_tb.sv =====
// ============================================================================
// refcounted_buffer_pool_tb
// Self-checking testbench for the reference-counted buffer pool. Commands
// are sent on the slave stream while a shadow copy of the free stack, the
// count table and the pool size works out the result of every accepted
// transfer. Each result transfer is compared field by field with the oldest
// pending prediction. The run covers directed corner cases, a fill of the
// stack to a small pool size, random command mixes at several pool sizes,
// random idling on both streams and a long result stall.
// ============================================================================
module refcounted_buffer_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BUFS    = rcbp_pkg::MAX_BUFFERS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int FILL_SIZE   = 40;

    typedef logic [rcbp_pkg::ID_W-1:0] t_id;

    typedef struct {
        rcbp_pkg::t_status            status;
        t_id                          buf_out;
        logic                         released;
        logic [rcbp_pkg::LEVEL_W-1:0] level;
    } t_pool_result;

    // DUT connections
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [rcbp_pkg::POOL_W-1:0]   i_cfg_wr_data = '0;
    logic                          s_tvalid      = 1'b0;
    logic                          s_tready;
    logic [rcbp_pkg::S_DATA_W-1:0] s_tdata       = '0;  // buf_id[9:0], ref_count[17:10]
    logic [rcbp_pkg::OP_W-1:0]     s_tuser       = '0;  // op[1:0]
    logic                          m_tvalid;
    logic                          m_tready      = 1'b0;
    logic [rcbp_pkg::M_DATA_W-1:0] m_tdata;             // buf_out[9:0], released[10],
                                                        // free_level[21:11]
    logic [rcbp_pkg::STATUS_W-1:0] m_tuser;             // status[1:0]

    // Shadow state of the pool
    t_id                           shadow_stack [MAX_BUFS];
    int                            shadow_top;
    logic [7:0]                    shadow_refs [rcbp_pkg::ID_SPACE];
    logic [rcbp_pkg::POOL_W-1:0]   shadow_pool_size;
    int                            live_ids [$];

    t_pool_result                  pending_results [$];

    // Idling controls and the receiver hold-off request
    int                            send_idle_pct;
    int                            recv_idle_pct = 0;
    logic                          hold_req      = 1'b0;
    logic                          hold_ack      = 1'b0;
    int                            hold_left     = 0;

    // Run statistics
    int                            fail_cnt      = 0;
    int                            sent_cnt      = 0;
    int                            result_cnt    = 0;
    int                            status_cnt [4] = '{0, 0, 0, 0};
    int                            stall_cycles  = 0;

    refcounted_buffer_pool u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Push an index onto the shadow free stack if there is room
    function automatic bit push_free(t_id id);
        int cap;
        cap = (shadow_pool_size > MAX_BUFS) ? MAX_BUFS : int'(shadow_pool_size);
        if (shadow_top >= cap || shadow_top >= MAX_BUFS) begin
            return 1'b0;
        end
        shadow_stack[shadow_top] = id;
        shadow_top++;
        return 1'b1;
    endfunction

    // Work out the result of one command and advance the shadow state
    function automatic t_pool_result predict_pool_op(rcbp_pkg::t_op op, t_id id,
                                                     logic [7:0] cnt);
        t_pool_result r;
        r.status   = rcbp_pkg::ST_OK;
        r.buf_out  = '0;
        r.released = 1'b0;
        case (op)
            rcbp_pkg::OP_ADD: begin
                if (!push_free(id)) r.status = rcbp_pkg::ST_FULL;
            end
            rcbp_pkg::OP_ALLOC: begin
                if (shadow_top == 0) begin
                    r.status = rcbp_pkg::ST_EMPTY;
                end else begin
                    shadow_top--;
                    r.buf_out = shadow_stack[shadow_top];
                    shadow_refs[r.buf_out] = cnt;
                    live_ids.push_back(int'(r.buf_out));
                end
            end
            rcbp_pkg::OP_FREE: begin
                if (shadow_refs[id] == 0) begin
                    r.status = rcbp_pkg::ST_ZERO;
                end else begin
                    shadow_refs[id] = shadow_refs[id] - 8'd1;
                    if (shadow_refs[id] == 0) begin
                        if (push_free(id)) r.released = 1'b1;
                        else r.status = rcbp_pkg::ST_FULL;
                    end
                end
            end
            default: ;
        endcase
        r.level = shadow_top[10:0];
        return r;
    endfunction

    // Offer one command, idling cycle by cycle first, and wait for its transfer
    task automatic send_cmd(input rcbp_pkg::t_op op, input t_id id,
                            input logic [7:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, cnt, id};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_results.push_back(predict_pool_op(op, id, cnt));
        sent_cnt++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the pool size while the block is idle
    task automatic write_pool_size(input logic [rcbp_pkg::POOL_W-1:0] size);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_pool_size = size;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    // One random command: mostly frees of live buffers, allocates and adds
    task automatic send_random_item();
        int         pick;
        int         idx;
        logic [7:0] cnt;
        pick = $urandom_range(99);
        cnt  = 8'($urandom_range(1, 3));
        if ($urandom_range(99) < 10) cnt = 8'd0;
        else if ($urandom_range(99) < 8) cnt = 8'($urandom_range(255));
        if (pick < 35) begin
            send_cmd(rcbp_pkg::OP_ALLOC, t_id'($urandom_range(1023)), cnt);
        end else if (pick < 70) begin
            if (live_ids.size() != 0 && $urandom_range(99) < 85) begin
                idx = $urandom_range(live_ids.size() - 1);
                send_cmd(rcbp_pkg::OP_FREE, t_id'(live_ids[idx]), 8'($urandom_range(255)));
                // drop buffers whose count has run out
                if (shadow_refs[live_ids[idx]] == 0) live_ids.delete(idx);
            end else begin
                send_cmd(rcbp_pkg::OP_FREE, t_id'($urandom_range(1023)),
                         8'($urandom_range(255)));
            end
        end else if (pick < 95) begin
            send_cmd(rcbp_pkg::OP_ADD, t_id'($urandom_range(1023)), 8'($urandom_range(255)));
        end else begin
            send_cmd(rcbp_pkg::OP_NONE, t_id'($urandom_range(1023)), 8'($urandom_range(255)));
        end
    endtask

    // Empty stack, zero counts, duplicates and the undefined op
    task automatic test_basic_ops();
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_FREE,  10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_NONE,  10'd1023, 8'd255);
        send_cmd(rcbp_pkg::OP_ADD,   10'd1023, 8'd0);
        send_cmd(rcbp_pkg::OP_ADD,   10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_ADD,   10'd0,    8'd255);
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_FREE,  10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd1023, 8'd255);
        send_cmd(rcbp_pkg::OP_FREE,  10'd0,    8'd0);
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd0,    8'd1);
    endtask

    // Zero capacity, size beyond the limit and capacity lowered below the fill
    task automatic test_pool_limits();
        write_pool_size(11'd0);
        send_cmd(rcbp_pkg::OP_ADD,   10'd7,    8'd0);
        send_cmd(rcbp_pkg::OP_FREE,  10'd1023, 8'd0);
        write_pool_size(11'd2047);
        send_cmd(rcbp_pkg::OP_ADD,   10'd1,    8'd0);
        send_cmd(rcbp_pkg::OP_ADD,   10'd2,    8'd0);
        send_cmd(rcbp_pkg::OP_ADD,   10'd3,    8'd0);
        write_pool_size(11'd2);
        send_cmd(rcbp_pkg::OP_ADD,   10'd4,    8'd0);
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd0,    8'd1);
        send_cmd(rcbp_pkg::OP_ADD,   10'd9,    8'd0);
        send_cmd(rcbp_pkg::OP_ALLOC, 10'd0,    8'd1);
        send_cmd(rcbp_pkg::OP_ADD,   10'd9,    8'd0);
        send_cmd(rcbp_pkg::OP_FREE,  10'd3,    8'd0);
    endtask

    // Fill the stack up to a small pool size, then push once more
    task automatic test_fill_to_capacity();
        write_pool_size(11'(FILL_SIZE));
        while (shadow_top < FILL_SIZE) begin
            send_cmd(rcbp_pkg::OP_ADD, t_id'(shadow_top), 8'($urandom_range(255)));
        end
        send_cmd(rcbp_pkg::OP_ADD, 10'd512, 8'd0);
    endtask

    task automatic test_random_mix(input int n_items,
                                   input logic [rcbp_pkg::POOL_W-1:0] size);
        write_pool_size(size);
        repeat (n_items) send_random_item();
    endtask

    // Hold the result stream off while commands keep coming, then pause
    task automatic test_result_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (24) send_random_item();
        send_idle_pct = saved_pct;
        wait_results_drained();
    endtask

    // Receiver: random idling, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_pool_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            result_cnt++;
            if (pending_results.size() == 0) begin
                $error("result with none pending: tuser %0d tdata 0x%06h", m_tuser, m_tdata);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                status_cnt[want.status]++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata[9:0] !== want.buf_out) begin
                    $error("buf_out: expected %0d, got %0d", want.buf_out, m_tdata[9:0]);
                    fail_cnt++;
                end
                if (m_tdata[10] !== want.released) begin
                    $error("released: expected %0d, got %0d", want.released, m_tdata[10]);
                    fail_cnt++;
                end
                if (m_tdata[21:11] !== want.level) begin
                    $error("free_level: expected %0d, got %0d", want.level, m_tdata[21:11]);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("refcounted_buffer_pool_tb: FAIL");
            $finish;
        end
    end

    initial begin
        shadow_top       = 0;
        shadow_pool_size = rcbp_pkg::POOL_SIZE_RST;
        send_idle_pct    = 0;
        foreach (shadow_refs[i]) shadow_refs[i] = '0;
        foreach (shadow_stack[i]) shadow_stack[i] = '0;

        // hold reset, then release it at a clock edge
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(26, 62);
        test_basic_ops();
        test_pool_limits();
        test_fill_to_capacity();
        test_random_mix(250, 11'd1024);

        set_idling(62, 26);
        test_result_backpressure();
        test_random_mix(230, 11'd16);

        set_idling(0, 0);
        test_random_mix(110, 11'd1);
        test_random_mix(110, 11'd2047);

        // let the last results come back, then a few more cycles
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_cnt++;
        end

        $display("Covered %0d commands and %0d results at pool sizes 1024, 0, 2047, 2, %0d, 16, 1",
                 sent_cnt, result_cnt, FILL_SIZE);
        $display("Statuses seen: ok %0d, full %0d, empty %0d, free at zero %0d",
                 status_cnt[rcbp_pkg::ST_OK], status_cnt[rcbp_pkg::ST_FULL],
                 status_cnt[rcbp_pkg::ST_EMPTY], status_cnt[rcbp_pkg::ST_ZERO]);
        if (fail_cnt == 0) begin
            $display("refcounted_buffer_pool_tb: PASS");
        end else begin
            $display("refcounted_buffer_pool_tb: FAIL");
        end
        $finish;
    end

endmodule
